// ===== hdl/lpr_pkg.sv =====
// Shared types and constants for the line pixel rasterizer.
// No dependencies; used by lpr_setup and line_pixel_rasterizer.
package lpr_pkg;

   localparam int COORD_BITS = 6;   // walk coordinate width, 2..6
   localparam int FIELD_BITS = 6;   // coordinate field width on the ports
   localparam int COLOR_BITS = 32;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      field_type start_x;
      field_type start_y;
      field_type end_x;
      field_type end_y;
      color_type pixel_color;
   } req_type;

   typedef struct packed {
      field_type pixel_x;
      field_type pixel_y;
      color_type out_color;
      logic      last_pixel;
   } rsp_type;

   // line parameters in walk order (major axis ascending)
   typedef struct packed {
      logic      steep;
      coord_type maj0;
      coord_type min0;
      coord_type span;
      coord_type adm;    // |minor delta|
      logic      neg;    // minor delta is negative
   } line_setup_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_WALK  = 3'b100
   } state_type;

endpackage

// ===== hdl/lpr_setup.sv =====
// Endpoint ordering for the line pixel rasterizer: picks the major axis,
// orders the endpoints along it and derives span and minor delta. Uses lpr_pkg.
module lpr_setup (
   input  lpr_pkg::coord_type      ax,
   input  lpr_pkg::coord_type      ay,
   input  lpr_pkg::coord_type      bx,
   input  lpr_pkg::coord_type      by,
   output lpr_pkg::line_setup_type setup
);
   import lpr_pkg::*;

   coord_type adx, ady;
   logic      steep;
   coord_type maj_a, min_a, maj_b, min_b;
   coord_type maj0, min0, maj1, min1;

   always_comb begin
      adx   = (ax >= bx) ? coord_type'(ax - bx) : coord_type'(bx - ax);
      ady   = (ay >= by) ? coord_type'(ay - by) : coord_type'(by - ay);
      // equal deltas keep x as the major axis
      steep = adx < ady;
      maj_a = steep ? ay : ax;
      min_a = steep ? ax : ay;
      maj_b = steep ? by : bx;
      min_b = steep ? bx : by;
      if (maj_a > maj_b) begin
         maj0 = maj_b;
         min0 = min_b;
         maj1 = maj_a;
         min1 = min_a;
      end else begin
         maj0 = maj_a;
         min0 = min_a;
         maj1 = maj_b;
         min1 = min_b;
      end
      setup.steep = steep;
      setup.maj0  = maj0;
      setup.min0  = min0;
      setup.span  = coord_type'(maj1 - maj0);
      setup.neg   = min0 > min1;
      setup.adm   = setup.neg ? coord_type'(min0 - min1) : coord_type'(min1 - min0);
   end

endmodule

// ===== hdl/line_pixel_rasterizer.sv =====
// Top level of the line pixel rasterizer: request capture, walk sequencer
// and output register. Uses lpr_pkg and lpr_setup.
//
// A line request from (start_x,start_y) to (end_x,end_y) comes out as
// span+1 pixels in increasing order of the major coordinate, where span is
// the larger absolute delta; the last one carries last_pixel. The request
// is taken in ST_IDLE, ST_SETUP orders the endpoints, then the walk loop
// gives one pixel per cycle while rsp_stall does not hold the output
// register, and its single add/compare/subtract step keeps the running
// remainder of minor delta times offset over span. req_stall is high from
// the accepted request until its last pixel is in the output register, so
// the next request is taken while that pixel still waits on rsp_stall.
module line_pixel_rasterizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpr_pkg::rsp_type rsp_data
);
   import lpr_pkg::*;

   state_type      state_ff, state_in;
   coord_type      ax_ff, ay_ff, bx_ff, by_ff;
   color_type      color_ff;
   line_setup_type setup_w;
   line_setup_type line_ff, line_in;
   coord_type      t_ff, t_in;
   coord_type      mj_ff, mj_in;
   coord_type      q_ff, q_in;
   coord_type      r_ff, r_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic                req_take;
   logic                out_free;
   logic [COORD_BITS:0] r_sum;
   coord_type           mn;
   coord_type           px, py;
   logic                last;

   lpr_setup u_setup (
      .ax    (ax_ff),
      .ay    (ay_ff),
      .bx    (bx_ff),
      .by    (by_ff),
      .setup (setup_w)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      line_in      = line_ff;
      t_in         = t_ff;
      mj_in        = mj_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // shared step: remainder += |dmin|, wrap once against span
      r_sum = {1'b0, r_ff} + {1'b0, line_ff.adm};
      mn    = line_ff.neg ? coord_type'(line_ff.min0 - q_ff)
                          : coord_type'(line_ff.min0 + q_ff);
      px    = line_ff.steep ? mn : mj_ff;
      py    = line_ff.steep ? mj_ff : mn;
      last  = (t_ff == line_ff.span);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            line_in  = setup_w;
            t_in     = '0;
            mj_in    = setup_w.maj0;
            q_in     = '0;
            r_in     = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (out_free) begin
               rsp_in.pixel_x    = field_type'(px);
               rsp_in.pixel_y    = field_type'(py);
               rsp_in.out_color  = color_ff;
               rsp_in.last_pixel = last;
               rsp_valid_in      = 1'b1;
               t_in              = coord_type'(t_ff + 1'b1);
               mj_in             = coord_type'(mj_ff + 1'b1);
               if (r_sum >= {1'b0, line_ff.span}) begin
                  r_in = coord_type'(r_sum - {1'b0, line_ff.span});
                  q_in = coord_type'(q_ff + 1'b1);
               end else begin
                  r_in = coord_type'(r_sum);
               end
               if (last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ax_ff    <= req_data.start_x[COORD_BITS-1:0];
         ay_ff    <= req_data.start_y[COORD_BITS-1:0];
         bx_ff    <= req_data.end_x[COORD_BITS-1:0];
         by_ff    <= req_data.end_y[COORD_BITS-1:0];
         color_ff <= req_data.pixel_color;
      end
      line_ff <= line_in;
      t_ff    <= t_in;
      mj_ff   <= mj_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for line_pixel_rasterizer: random and directed lines
// against an in-bench division-based line predictor. Depends on lpr_pkg and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lpr_pkg::*;

   localparam int COORD_MASK  = (1 << COORD_BITS) - 1;
   localparam int FIELD_MAX   = (1 << FIELD_BITS) - 1;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_PAUSE = 8;
   localparam int MAX_GAP     = 40;
   localparam int QUIET_LIMIT = 2000;

   // expected pixel queue plus the line walk that fills it
   class line_scoreboard;
      rsp_type expected_pixels[$];
      int      lines_noted;
      int      pixels_checked;
      int      mismatches;

      task report_mismatch(input string what);
         if (mismatches < 40) begin
            $display("%0t: mismatch: %s", $time, what);
         end
         mismatches++;
      endtask

      function void note_line(input req_type line);
         int      ax, ay, bx, by, dx, dy;
         int      maj0, min0, maj1, min1, swap, span, dmin, mn, mj;
         bit      steep;
         rsp_type pixel;
         ax = int'(line.start_x) & COORD_MASK;
         ay = int'(line.start_y) & COORD_MASK;
         bx = int'(line.end_x) & COORD_MASK;
         by = int'(line.end_y) & COORD_MASK;
         dx = bx - ax;
         dy = by - ay;
         // ties go to x as the major axis
         steep = ((dx < 0) ? -dx : dx) < ((dy < 0) ? -dy : dy);
         if (steep) begin
            maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
         end else begin
            maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
         end
         if (maj0 > maj1) begin
            swap = maj0; maj0 = maj1; maj1 = swap;
            swap = min0; min0 = min1; min1 = swap;
         end
         span = maj1 - maj0;
         dmin = min1 - min0;
         for (int t = 0; t <= span; t++) begin
            // SV integer division truncates toward zero
            mn = (span != 0) ? min0 + (dmin * t) / span : min0;
            mj = maj0 + t;
            pixel.pixel_x    = field_type'(steep ? mn : mj);
            pixel.pixel_y    = field_type'(steep ? mj : mn);
            pixel.out_color  = line.pixel_color;
            pixel.last_pixel = (t == span);
            expected_pixels.push_back(pixel);
         end
         lines_noted++;
      endfunction

      task check_pixel(input rsp_type got);
         rsp_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel (%0d,%0d) with no line outstanding",
                                      got.pixel_x, got.pixel_y));
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (got.pixel_x != want.pixel_x)
            report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                      got.pixel_x, want.pixel_x));
         if (got.pixel_y != want.pixel_y)
            report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                      got.pixel_y, want.pixel_y));
         if (got.out_color != want.out_color)
            report_mismatch($sformatf("out_color %h, expected %h",
                                      got.out_color, want.out_color));
         if (got.last_pixel != want.last_pixel)
            report_mismatch($sformatf("last_pixel %0b, expected %0b at (%0d,%0d)",
                                      got.last_pixel, want.last_pixel,
                                      want.pixel_x, want.pixel_y));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int holds_asked   = 0;
   int holds_done    = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   line_scoreboard sb = new;

   line_pixel_rasterizer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stall, or a long hold-off when one is asked for
   initial begin
      forever begin
         @(negedge clock);
         if (holds_asked != holds_done) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            sb.note_line(req_data);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_pixel(rsp_data);
            quiet_cycles = 0;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic req_type make_line(input int ax, ay, bx, by, input color_type color);
      req_type line;
      line.start_x     = field_type'(ax);
      line.start_y     = field_type'(ay);
      line.end_x       = field_type'(bx);
      line.end_y       = field_type'(by);
      line.pixel_color = color;
      return line;
   endfunction

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : ((v > FIELD_MAX) ? FIELD_MAX : v);
   endfunction

   function automatic req_type random_line();
      int ax, ay, bx, by, pick, adx, swap;
      ax   = $urandom_range(FIELD_MAX);
      ay   = $urandom_range(FIELD_MAX);
      bx   = $urandom_range(FIELD_MAX);
      by   = $urandom_range(FIELD_MAX);
      pick = $urandom_range(99);
      if (pick < 25) begin
         // short lines, including zero length
         bx = clamp_coord(ax + $urandom_range(6) - 3);
         by = clamp_coord(ay + $urandom_range(6) - 3);
      end else if (pick < 35) begin
         case ($urandom_range(2))
            0: by = ay;
            1: bx = ax;
            default: begin
               adx = (bx > ax) ? bx - ax : ax - bx;
               ay  = $urandom_range(FIELD_MAX - adx);
               by  = ay + adx;
               if ($urandom_range(1)) begin
                  swap = ay; ay = by; by = swap;
               end
            end
         endcase
      end
      return make_line(ax, ay, bx, by, $urandom());
   endfunction

   // entered and left just after a falling edge
   task automatic send_line(input req_type line);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= line;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   task automatic random_phase(input int send_pct, input int stall_in, input int count);
      send_idle_pct = send_pct;
      stall_pct    <= stall_in;
      repeat (count) send_line(random_line());
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero length, both corners
      send_line(make_line(0, 0, 0, 0, 32'h0000_0000));
      send_line(make_line(63, 63, 63, 63, 32'hFFFF_FFFF));
      // full-span horizontal and vertical, both directions
      send_line(make_line(0, 0, 63, 0, 32'hAAAA_AAAA));
      send_line(make_line(63, 5, 0, 5, 32'h5555_5555));
      send_line(make_line(7, 0, 7, 63, 32'h0123_4567));
      send_line(make_line(9, 63, 9, 0, 32'h89AB_CDEF));
      // equal deltas keep x as the major axis
      send_line(make_line(0, 0, 63, 63, 32'hFFFF_0000));
      send_line(make_line(63, 0, 0, 63, 32'h0000_FFFF));
      send_line(make_line(0, 63, 63, 0, 32'hF0F0_F0F0));
      send_line(make_line(13, 13, 10, 10, 32'h0F0F_0F0F));
      // shallow and steep, positive and negative minor delta
      send_line(make_line(0, 0, 63, 1, 32'h8000_0001));
      send_line(make_line(0, 0, 1, 63, 32'h7FFF_FFFE));
      send_line(make_line(63, 0, 62, 63, 32'hDEAD_BEEF));
      send_line(make_line(20, 40, 50, 10, 32'hCAFE_F00D));
      send_line(make_line(5, 60, 0, 2, 32'h1234_5678));
      send_line(make_line(50, 3, 17, 29, 32'h9ABC_DEF0));
      // single-step lines
      send_line(make_line(0, 0, 1, 0, 32'h0000_0001));
      send_line(make_line(0, 1, 0, 0, 32'h8000_0000));
      send_line(make_line(31, 32, 32, 31, 32'h3C3C_3C3C));

      // long output hold while requests keep coming; the block backs up
      holds_asked <= holds_asked + 1;
      repeat (12) send_line(random_line());
      wait_drained();

      random_phase(0, 0, 100);
      random_phase(77, 0, 85);
      random_phase(0, 77, 85);
      random_phase(13, 13, 85);

      $display("drew %0d lines, %0d pixels compared, %0d mismatches", sb.lines_noted,
               sb.pixels_checked, sb.mismatches);
      $display("pacing: free-running, sparse requests, heavy output stall, light both, one long hold");
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
